[rtl/rsa_pkg.sv]
// Shared types and codes for the refcounted slot allocator.
package rsa_pkg;

   localparam int CMD_W    = 3;
   localparam int IDX_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 9;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_ALLOC_ITEM = 3'd0;
   localparam cmd_type CMD_FREE_ITEM  = 3'd1;
   localparam cmd_type CMD_ALLOC_DATA = 3'd2;
   localparam cmd_type CMD_FREE_DATA  = 3'd3;
   localparam cmd_type CMD_ADD_LINK   = 3'd4;

   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_EMPTY  = 3'd1;
   localparam status_type ST_LINKED = 3'd2;
   localparam status_type ST_FULL   = 3'd3;
   localparam status_type ST_SAT    = 3'd4;

   // Operations of the shared increment/decrement unit.
   typedef enum logic [1:0] {
      ALU_INC_WRAP,
      ALU_INC,
      ALU_DEC_FLOOR
   } alu_op_type;

endpackage

[rtl/rsa_req_if.sv]
// Command channel: valid/ready plus one command item.
interface rsa_req_if import rsa_pkg::*; ();
   logic             valid;
   logic             ready;
   cmd_type          command;
   logic [IDX_W-1:0] item_index;
   logic [IDX_W-1:0] data_index;
   logic             item_has_data;

   modport source (output valid, command, item_index, data_index, item_has_data,
                   input ready);
   modport sink (input valid, command, item_index, data_index, item_has_data,
                 output ready);
endinterface

[rtl/rsa_rsp_if.sv]
// Response channel: valid/ready plus one response item.
interface rsa_rsp_if import rsa_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [IDX_W-1:0]   slot_index;
   logic               data_released;
   logic [COUNT_W-1:0] free_item_slots;
   logic [COUNT_W-1:0] free_data_slots;

   modport source (output valid, status, slot_index, data_released, free_item_slots,
                   free_data_slots, input ready);
   modport sink (input valid, status, slot_index, data_released, free_item_slots,
                 free_data_slots, output ready);
endinterface

[rtl/rsa_alu.sv]
// Shared increment/decrement unit for pointers, free counts and link counts.
module rsa_alu import rsa_pkg::*; #(
   parameter int WIDTH = 16
) (
   input  alu_op_type       op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] lim,
   output logic [WIDTH-1:0] res,
   output logic             at_lim,
   output logic             res_zero
);

   logic [WIDTH:0] sum;

   assign sum    = {1'b0, a} + 1'b1;
   assign at_lim = (a == lim);

   always_comb begin
      case (op)
         ALU_INC_WRAP: res = (sum >= {1'b0, lim}) ? '0 : sum[WIDTH-1:0];
         ALU_INC:      res = sum[WIDTH-1:0];
         ALU_DEC_FLOOR: res = (a == '0) ? '0 : a - 1'b1;
         default:      res = a;
      endcase
   end

   assign res_zero = (res == '0);

endmodule

[rtl/rsa_ring_mem.sv]
// Free-index ring storage; entries not yet written read as their own address.
module rsa_ring_mem #(
   parameter int SLOTS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS+1)-1:0] wr_addr,
   input  logic [$clog2(SLOTS)-1:0]   wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(SLOTS+1)-1:0] rd_addr,
   output logic [$clog2(SLOTS)-1:0]   rd_data
);

   localparam int PW = $clog2(SLOTS + 1);
   localparam int EW = $clog2(SLOTS);

   logic [EW-1:0] entry_ff [SLOTS+1];
   logic [EW-1:0] mem_q_ff;
   logic [EW-1:0] init_q_ff;
   logic          use_init_ff;
   // Writes walk the ring in order, so entries below the mark have been written.
   logic [PW-1:0] mark_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= entry_ff[rd_addr];
         init_q_ff   <= EW'(rd_addr);
         use_init_ff <= (rd_addr >= mark_ff) && (32'(rd_addr) < SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else if (wr_en && (wr_addr == mark_ff) && (32'(mark_ff) < SLOTS)) begin
         mark_ff <= mark_ff + 1'b1;
      end
   end

   assign rd_data = use_init_ff ? init_q_ff : mem_q_ff;

endmodule

[rtl/rsa_link_mem.sv]
// Link count storage with per-slot valid bits; an unwritten slot reads zero.
module rsa_link_mem #(
   parameter int SLOTS     = 256,
   parameter int LINK_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [LINK_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [LINK_BITS-1:0]     rd_data
);

   logic [LINK_BITS-1:0] link_ff [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   logic [LINK_BITS-1:0] q_ff;
   logic                 q_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= link_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

[rtl/refcounted_slot_allocator.sv]
// Refcounted slot allocator: two ring free lists plus per-data-slot link counts.
// Flow: S_START leads to S_DONE (result load) for an empty pool, an unknown command or
//   a bad data index on a data free or link add; an allocation passes S_POP_CNT, and
//   an item free with data up to S_LINK_OP, S_DPUSH, S_DPUSH_CNT, S_IPUSH, S_IPUSH_CNT.
//   One command at a time; a held response stalls S_DONE; one ALU update per cycle.
// Reset (synchronous): rings hold all indices in order, all link counts zero.
module refcounted_slot_allocator import rsa_pkg::*; #(
   parameter int ITEM_SLOTS = 256,
   parameter int DATA_SLOTS = 256,
   parameter int LINK_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   rsa_req_if.sink    req_chan,
   rsa_rsp_if.source  rsp_chan
);

   localparam int IPW = $clog2(ITEM_SLOTS + 1);   // item pointer / count width
   localparam int IEW = $clog2(ITEM_SLOTS);       // item index width
   localparam int DPW = $clog2(DATA_SLOTS + 1);
   localparam int DEW = $clog2(DATA_SLOTS);
   localparam int PMAX = (IPW > DPW) ? IPW : DPW;
   localparam int AW   = (LINK_BITS > PMAX) ? LINK_BITS : PMAX;

   localparam logic [AW-1:0] ITEM_WRAP = AW'(ITEM_SLOTS + 1);
   localparam logic [AW-1:0] DATA_WRAP = AW'(DATA_SLOTS + 1);
   localparam logic [AW-1:0] LINK_MAX  = AW'({LINK_BITS{1'b1}});

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_POP_CNT,
      S_LINK_OP,
      S_DPUSH,
      S_DPUSH_CNT,
      S_IPUSH,
      S_IPUSH_CNT,
      S_DONE
   } state_type;

   state_type state_ff;

   // latched command
   cmd_type          cmd_ff;
   logic [IDX_W-1:0] ii_ff;
   logic [IDX_W-1:0] di_ff;
   logic             has_ff;

   // working result
   status_type       status_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             rel_ff;

   // ring pointers and free counts
   logic [IPW-1:0] i_rd_ff, i_wr_ff, i_cnt_ff;
   logic [DPW-1:0] d_rd_ff, d_wr_ff, d_cnt_ff;

   // response register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [IDX_W-1:0]   rsp_slot_ff;
   logic               rsp_rel_ff;
   logic [COUNT_W-1:0] rsp_ifree_ff;
   logic [COUNT_W-1:0] rsp_dfree_ff;

   // shared unit
   alu_op_type    alu_op;
   logic [AW-1:0] alu_a, alu_lim, alu_res;
   logic          alu_at_lim, alu_res_zero;

   // memory ports
   logic           iring_wr_en, iring_rd_en;
   logic [IEW-1:0] iring_rd_data;
   logic           dring_wr_en, dring_rd_en;
   logic [DEW-1:0] dring_rd_data;
   logic                 link_wr_en, link_rd_en;
   logic [DEW-1:0]       link_wr_addr;
   logic [LINK_BITS-1:0] link_wr_data, link_rd_data;

   logic      ii_ok, di_ok, i_full, d_full, i_empty, d_empty;
   logic      is_add_link;
   state_type after_data;

   assign ii_ok   = 32'(ii_ff) < ITEM_SLOTS;
   assign di_ok   = 32'(di_ff) < DATA_SLOTS;
   assign i_full  = 32'(i_cnt_ff) >= ITEM_SLOTS;
   assign d_full  = 32'(d_cnt_ff) >= DATA_SLOTS;
   assign i_empty = (i_cnt_ff == '0);
   assign d_empty = (d_cnt_ff == '0);
   assign is_add_link = (cmd_ff == CMD_ADD_LINK);
   // an item free continues with its own push once the data part is done
   assign after_data = (cmd_ff == CMD_FREE_ITEM) ? S_IPUSH : S_DONE;

   // Operand select for the shared unit: one update per sequencer step.
   always_comb begin
      alu_op  = ALU_INC;
      alu_a   = '0;
      alu_lim = '0;
      case (state_ff)
         S_START: begin
            alu_op = ALU_INC_WRAP;
            if (cmd_ff == CMD_ALLOC_DATA) begin
               alu_a   = AW'(d_rd_ff);
               alu_lim = DATA_WRAP;
            end else begin
               alu_a   = AW'(i_rd_ff);
               alu_lim = ITEM_WRAP;
            end
         end
         S_POP_CNT: begin
            alu_op = ALU_DEC_FLOOR;
            alu_a  = (cmd_ff == CMD_ALLOC_DATA) ? AW'(d_cnt_ff) : AW'(i_cnt_ff);
         end
         S_LINK_OP: begin
            alu_op  = is_add_link ? ALU_INC : ALU_DEC_FLOOR;
            alu_a   = AW'(link_rd_data);
            alu_lim = LINK_MAX;
         end
         S_DPUSH: begin
            alu_op  = ALU_INC_WRAP;
            alu_a   = AW'(d_wr_ff);
            alu_lim = DATA_WRAP;
         end
         S_DPUSH_CNT: begin
            alu_a = AW'(d_cnt_ff);
         end
         S_IPUSH: begin
            alu_op  = ALU_INC_WRAP;
            alu_a   = AW'(i_wr_ff);
            alu_lim = ITEM_WRAP;
         end
         S_IPUSH_CNT: begin
            alu_a = AW'(i_cnt_ff);
         end
         default: begin
            alu_op = ALU_INC;
         end
      endcase
   end

   rsa_alu #(
      .WIDTH (AW)
   ) u_alu (
      .op       (alu_op),
      .a        (alu_a),
      .lim      (alu_lim),
      .res      (alu_res),
      .at_lim   (alu_at_lim),
      .res_zero (alu_res_zero)
   );

   // Memory controls. Ring reads issue in S_START, data is used in S_POP_CNT.
   assign iring_rd_en = (state_ff == S_START) && (cmd_ff == CMD_ALLOC_ITEM) && !i_empty;
   assign dring_rd_en = (state_ff == S_START) && (cmd_ff == CMD_ALLOC_DATA) && !d_empty;
   assign iring_wr_en = (state_ff == S_IPUSH) && ii_ok && !i_full;
   assign dring_wr_en = (state_ff == S_DPUSH) && !d_full;

   assign link_rd_en = (state_ff == S_START) && di_ok &&
                       ((cmd_ff == CMD_FREE_DATA) || is_add_link ||
                        ((cmd_ff == CMD_FREE_ITEM) && has_ff));

   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = DEW'(di_ff);
      link_wr_data = LINK_BITS'(alu_res);
      if ((state_ff == S_POP_CNT) && (cmd_ff == CMD_ALLOC_DATA)) begin
         // fresh data slot starts with no links
         link_wr_en   = 1'b1;
         link_wr_addr = dring_rd_data;
         link_wr_data = '0;
      end else if (state_ff == S_LINK_OP) begin
         link_wr_en = !(is_add_link && alu_at_lim);
      end
   end

   rsa_ring_mem #(
      .SLOTS (ITEM_SLOTS)
   ) u_item_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (iring_wr_en),
      .wr_addr (i_wr_ff),
      .wr_data (IEW'(ii_ff)),
      .rd_en   (iring_rd_en),
      .rd_addr (i_rd_ff),
      .rd_data (iring_rd_data)
   );

   rsa_ring_mem #(
      .SLOTS (DATA_SLOTS)
   ) u_data_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (dring_wr_en),
      .wr_addr (d_wr_ff),
      .wr_data (DEW'(di_ff)),
      .rd_en   (dring_rd_en),
      .rd_addr (d_rd_ff),
      .rd_data (dring_rd_data)
   );

   rsa_link_mem #(
      .SLOTS     (DATA_SLOTS),
      .LINK_BITS (LINK_BITS)
   ) u_link (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (DEW'(di_ff)),
      .rd_data (link_rd_data)
   );

   // Sequencer, pool state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_rd_ff      <= '0;
         i_wr_ff      <= IPW'(ITEM_SLOTS);
         i_cnt_ff     <= IPW'(ITEM_SLOTS);
         d_rd_ff      <= '0;
         d_wr_ff      <= DPW'(DATA_SLOTS);
         d_cnt_ff     <= DPW'(DATA_SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_DONE reloads the response itself when the held one drains
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff    <= req_chan.command;
                  ii_ff     <= req_chan.item_index;
                  di_ff     <= req_chan.data_index;
                  has_ff    <= req_chan.item_has_data;
                  status_ff <= ST_OK;
                  slot_ff   <= '0;
                  rel_ff    <= 1'b0;
                  state_ff  <= S_START;
               end
            end
            S_START: begin
               case (cmd_ff)
                  CMD_ALLOC_ITEM: begin
                     if (i_empty) begin
                        status_ff <= ST_EMPTY;
                        state_ff  <= S_DONE;
                     end else begin
                        i_rd_ff  <= IPW'(alu_res);
                        state_ff <= S_POP_CNT;
                     end
                  end
                  CMD_ALLOC_DATA: begin
                     if (d_empty) begin
                        status_ff <= ST_EMPTY;
                        state_ff  <= S_DONE;
                     end else begin
                        d_rd_ff  <= DPW'(alu_res);
                        state_ff <= S_POP_CNT;
                     end
                  end
                  CMD_FREE_ITEM: begin
                     if (!has_ff) begin
                        state_ff <= S_IPUSH;
                     end else if (di_ok) begin
                        state_ff <= S_LINK_OP;
                     end else begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_IPUSH;
                     end
                  end
                  CMD_FREE_DATA, CMD_ADD_LINK: begin
                     if (di_ok) begin
                        state_ff <= S_LINK_OP;
                     end else begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_DONE;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;   // unknown command: no effect
                  end
               endcase
            end
            S_POP_CNT: begin
               if (cmd_ff == CMD_ALLOC_DATA) begin
                  d_cnt_ff <= DPW'(alu_res);
                  slot_ff  <= IDX_W'(dring_rd_data);
               end else begin
                  i_cnt_ff <= IPW'(alu_res);
                  slot_ff  <= IDX_W'(iring_rd_data);
               end
               state_ff <= S_DONE;
            end
            S_LINK_OP: begin
               if (is_add_link) begin
                  if (alu_at_lim) begin
                     status_ff <= ST_SAT;
                  end
                  state_ff <= S_DONE;
               end else if (!alu_res_zero) begin
                  status_ff <= ST_LINKED;
                  state_ff  <= after_data;
               end else begin
                  state_ff <= S_DPUSH;
               end
            end
            S_DPUSH: begin
               if (d_full) begin
                  status_ff <= ST_FULL;
                  state_ff  <= after_data;
               end else begin
                  d_wr_ff  <= DPW'(alu_res);
                  state_ff <= S_DPUSH_CNT;
               end
            end
            S_DPUSH_CNT: begin
               d_cnt_ff <= DPW'(alu_res);
               rel_ff   <= 1'b1;
               state_ff <= after_data;
            end
            S_IPUSH: begin
               // a dropped item push overrides any data-side status
               if (!ii_ok || i_full) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  i_wr_ff  <= IPW'(alu_res);
                  state_ff <= S_IPUSH_CNT;
               end
            end
            S_IPUSH_CNT: begin
               i_cnt_ff <= IPW'(alu_res);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // wait here only while the previous response is still held
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_slot_ff   <= slot_ff;
                  rsp_rel_ff    <= rel_ff;
                  rsp_ifree_ff  <= COUNT_W'(i_cnt_ff);
                  rsp_dfree_ff  <= COUNT_W'(d_cnt_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !reset;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.slot_index      = rsp_slot_ff;
   assign rsp_chan.data_released   = rsp_rel_ff;
   assign rsp_chan.free_item_slots = rsp_ifree_ff;
   assign rsp_chan.free_data_slots = rsp_dfree_ff;

   // Pointer distance matches the free count whenever the sequencer is idle.
   a_item_ring_occ: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
      (((32'(i_wr_ff) >= 32'(i_rd_ff)) ? (32'(i_wr_ff) - 32'(i_rd_ff))
        : (32'(i_wr_ff) + ITEM_SLOTS + 1 - 32'(i_rd_ff))) == 32'(i_cnt_ff)))
      else $error("item ring pointers disagree with free count");

   a_data_ring_occ: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
      (((32'(d_wr_ff) >= 32'(d_rd_ff)) ? (32'(d_wr_ff) - 32'(d_rd_ff))
        : (32'(d_wr_ff) + DATA_SLOTS + 1 - 32'(d_rd_ff))) == 32'(d_cnt_ff)))
      else $error("data ring pointers disagree with free count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(i_cnt_ff) <= ITEM_SLOTS) && (32'(d_cnt_ff) <= DATA_SLOTS))
      else $error("free count above pool size");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (iring_rd_en |-> !i_empty) and (dring_rd_en |-> !d_empty))
      else $error("pop issued on an empty ring");

   // a release may still be followed by a dropped item push
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rel_ff) |->
      ((rsp_status_ff == ST_OK) || (rsp_status_ff == ST_FULL)))
      else $error("data release reported with unexpected status");

endmodule
